FILE: rtl/sbh_pkg.sv
// sbh_pkg: shared types, register indexes and hash constants for the string bucket hash.
// Used by sbh_front, sbh_queue, sbh_back, string_bucket_hash_core and the dv checker and bench.
`default_nettype none

package sbh_pkg;

    // hash_mode codes
    localparam logic [1:0] MODE_POLY  = 2'd0;
    localparam logic [1:0] MODE_SHIFT = 2'd1;
    localparam logic [1:0] MODE_SUM   = 2'd2;
    localparam logic [1:0] MODE_PROD  = 2'd3;

    // configuration register indexes
    localparam logic REG_HASH_MODE    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    localparam logic [1:0]  HASH_MODE_RST    = MODE_POLY;
    localparam logic [16:0] BUCKET_COUNT_RST = 17'd1024;

    // polynomial hash: h = (127*h + c) mod 16908799
    localparam logic [31:0] POLY_MULT   = 32'd127;
    localparam logic [31:0] POLY_PRIME  = 32'd16908799;
    localparam logic [31:0] POLY_PRIME2 = 32'd33817598;
    // quotient estimate: floor(t / 2^17) * 507 / 2^16 undershoots t / P by at most two
    localparam int          QEST_SHIFT  = 17;
    localparam logic [8:0]  QEST_RECIP  = 9'd507;

    localparam int SHIFT_BITS = 6;

    // restoring divider: one quotient bit per cycle over the 32-bit hash
    localparam int DIV_STEPS = 32;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
    } t_job;

    function automatic logic [31:0] start_value(input logic [1:0] mode);
        start_value = (mode == MODE_PROD) ? 32'd1 : 32'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sbh_front.sv
// sbh_front: accepts key bytes, folds them into the running hash and queues finished keys.
// Depends on sbh_pkg.
`default_nettype none

module sbh_front
    import sbh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_empty_key,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_full,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_QEST = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic        r_open, n_open;
    logic [31:0] r_h, n_h;
    logic [31:0] r_t, n_t;
    logic [7:0]  r_q, n_q;
    logic        r_last, n_last;

    logic        accept;
    logic [31:0] base;
    logic [31:0] c32;
    logic [31:0] fold;
    logic [31:0] red;
    logic [23:0] qprod;

    assign o_ready = (r_state == ST_IDLE) && !i_full;
    assign accept  = i_valid && o_ready;
    assign base    = r_open ? r_h : start_value(i_mode);
    assign c32     = {{24{i_key_byte[7]}}, i_key_byte};
    assign qprod   = 24'(r_t[31:QEST_SHIFT]) * 24'(QEST_RECIP);

    always_comb begin
        unique case (i_mode)
            MODE_POLY:  fold = 32'(base * POLY_MULT) + c32;
            MODE_SHIFT: fold = {base[31-SHIFT_BITS:0], i_key_byte[SHIFT_BITS-1:0]};
            MODE_SUM:   fold = base + c32;
            default:    fold = 32'(base * c32);
        endcase
    end

    // remainder after the estimate lies below three times the prime
    always_comb begin
        priority if (r_t >= POLY_PRIME2) begin
            red = r_t - POLY_PRIME2;
        end else if (r_t >= POLY_PRIME) begin
            red = r_t - POLY_PRIME;
        end else begin
            red = r_t;
        end
    end

    always_comb begin
        n_state = r_state;
        n_open  = r_open;
        n_h     = r_h;
        n_t     = r_t;
        n_q     = r_q;
        n_last  = r_last;
        o_push  = 1'b0;
        o_job   = '{mode: i_mode, value: fold};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_empty_key) begin
                        o_push = 1'b1;
                        o_job  = '{mode: i_mode, value: start_value(i_mode)};
                        n_open = 1'b0;
                    end else if (i_mode == MODE_POLY) begin
                        n_t     = fold;
                        n_last  = i_last_byte;
                        n_state = ST_QEST;
                    end else begin
                        n_h    = fold;
                        o_push = i_last_byte;
                        n_open = !i_last_byte;
                    end
                end
            end
            ST_QEST: begin
                n_q     = qprod[23:16];
                n_state = ST_RED;
            end
            ST_RED: begin
                n_t     = r_t - (32'(r_q) * POLY_PRIME);
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_h     = red;
                o_push  = r_last;
                o_job   = '{mode: MODE_POLY, value: red};
                n_open  = !r_last;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_open  <= 1'b0;
            r_h     <= '0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_h     <= n_h;
        end
        r_t    <= n_t;
        r_q    <= n_q;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

FILE: rtl/sbh_queue.sv
// sbh_queue: short register queue of finished hashes between front and back.
// Depends on sbh_pkg.
`default_nettype none

module sbh_queue
    import sbh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= PW'((32'(r_wr) + 1) % QDEPTH);
            end
            if (do_pop) begin
                r_rd <= PW'((32'(r_rd) + 1) % QDEPTH);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbh_back.sv
// sbh_back: takes finished hashes, reduces them modulo the bucket count in a
// bit-serial restoring divider and holds the result in the output register. Depends on sbh_pkg.
`default_nettype none

module sbh_back
    import sbh_pkg::*;
#(
    parameter int MAX_BUCKETS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_job             i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    input  wire logic [16:0] i_bucket_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_bucket_index
);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_DIV  = 2'd1;
    localparam logic [1:0] BK_DONE = 2'd2;
    localparam int CNTW = $clog2(DIV_STEPS);

    logic [1:0]      r_state;
    logic [31:0]     r_dvd;
    logic [16:0]     r_rem;
    logic [16:0]     r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_out_valid;
    logic [15:0]     r_out;

    logic [16:0] div_eff;
    logic [31:0] mag;
    logic [17:0] shifted;
    logic [17:0] diff;
    logic        out_free;

    always_comb begin
        priority if (i_bucket_count == '0) begin
            div_eff = 17'd1;
        end else if (32'(i_bucket_count) > 32'(MAX_BUCKETS)) begin
            div_eff = 17'(MAX_BUCKETS);
        end else begin
            div_eff = i_bucket_count;
        end
    end

    // sum and product modes reduce the magnitude
    assign mag = (i_job.mode[1] && i_job.value[31]) ? (32'd0 - i_job.value) : i_job.value;

    assign shifted  = {r_rem, r_dvd[31]};
    assign diff     = shifted - {1'b0, r_div};
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == BK_IDLE) && !i_empty;

    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // load a new transaction when the register frees up, drop it once taken
            if (r_state == BK_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                BK_IDLE: begin
                    if (!i_empty) begin
                        r_cnt   <= '0;
                        r_state <= BK_DIV;
                    end
                end
                BK_DIV: begin
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                        r_state <= BK_DONE;
                    end
                end
                BK_DONE: begin
                    if (out_free) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: r_state <= BK_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE) begin
            r_dvd <= mag;
            r_rem <= '0;
            r_div <= div_eff;
        end else if (r_state == BK_DIV) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= diff[17] ? shifted[16:0] : diff[16:0];
        end
        if (r_state == BK_DONE && out_free) begin
            r_out <= r_rem[15:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/string_bucket_hash_core.sv
// string_bucket_hash_core: streaming string hash with reduction to a bucket index.
// Shift-or, sum and product fold a byte straight into the running hash; the polynomial mode
// takes a byte through the estimate, multiply-subtract and correct states before the next.
// The back end reduces one hash at a time in the 32-step restoring divider and pops the next
// only once the result is loaded; a 4-entry queue lets the front keep taking bytes meanwhile.
// Reset is synchronous, active low, and restores the registers to their defaults and empties
// key state, queue and output. Depends on sbh_pkg, sbh_front, sbh_queue, sbh_back.
`default_nettype none

module string_bucket_hash_core
    import sbh_pkg::*;
#(
    parameter int MAX_BUCKETS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  wire logic        s_axis_tlast,   // last_byte
    input  wire logic        s_axis_tuser,   // [0] empty_key
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] bucket_index
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);

    logic [1:0]  r_hash_mode;
    logic [16:0] r_bucket_count;

    logic push, pop, q_empty, q_full;
    t_job push_job, head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode    <= HASH_MODE_RST;
            r_bucket_count <= BUCKET_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HASH_MODE:    r_hash_mode    <= i_cfg_data[1:0];
                REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_key_byte  (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_empty_key (s_axis_tuser),
        .i_mode      (r_hash_mode),
        .i_full      (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    sbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sbh_back #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_bucket_count (r_bucket_count),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_bucket_index (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/sbh_checker.sv
// sbh_checker: port-level assertions for string_bucket_hash_core, attached by bind.
// Sees only the top-level ports.
`default_nettype none

module sbh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // a result under stall holds its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // every result passes through the serial divider, so none appears soon after reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(i_rst_n, 16))
        else $error("result too soon after reset");

    // the output register only reloads once the previous transaction is taken
    a_one_per_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(m_axis_tvalid) && $past(!m_axis_tready) && $past(i_rst_n))
            |-> m_axis_tvalid)
        else $error("pending result lost");

endmodule

bind string_bucket_hash_core sbh_checker u_sbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/string_bucket_hash_checker.sv
`timescale 1ns / 100ps
// string_bucket_hash_checker: watches the key, config and result channels of the core,
// predicts each bucket index and compares it with the result stream. Depends on sbh_pkg.

module string_bucket_hash_checker
    import sbh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  wire logic        s_axis_tlast,   // last_byte
    input  wire logic        s_axis_tuser,   // [0] empty_key
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [15:0] bucket_index
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    localparam logic [31:0] BUCKET_LIMIT = 32'd65536;
    localparam logic [31:0] LOW_SIX_MASK = 32'd63;

    logic [1:0]  hash_mode_q    = HASH_MODE_RST;
    logic [16:0] bucket_count_q = BUCKET_COUNT_RST;
    logic [31:0] key_hash       = '0;
    logic        key_open       = 1'b0;
    logic [15:0] expected_index[$];
    logic [15:0] oldest_index;
    int          fail_count     = 0;

    function automatic logic [31:0] key_seed(input logic [1:0] mode);
        key_seed = (mode == MODE_PROD) ? 32'd1 : 32'd0;
    endfunction

    function automatic logic [31:0] fold_char(input logic [1:0] mode, input logic [31:0] h,
                                              input logic [7:0] b);
        logic [31:0] c;
        c = {{24{b[7]}}, b};
        case (mode)
            MODE_POLY:  fold_char = (POLY_MULT * h + c) % POLY_PRIME;
            MODE_SHIFT: fold_char = (h << SHIFT_BITS) | (c & LOW_SIX_MASK);
            MODE_SUM:   fold_char = h + c;
            default:    fold_char = h * c;
        endcase
    endfunction

    function automatic logic [15:0] bucket_of(input logic [1:0] mode, input logic [31:0] h);
        logic [31:0] mag;
        logic [31:0] n;
        logic [31:0] rem;
        mag = h;
        // signed hashes reduce by magnitude; -2^31 stays 2^31 as unsigned
        if ((mode == MODE_SUM || mode == MODE_PROD) && mag[31])
            mag = 32'd0 - mag;
        n = {15'd0, bucket_count_q};
        if (n == 32'd0)
            n = 32'd1;
        else if (n > BUCKET_LIMIT)
            n = BUCKET_LIMIT;
        rem = mag % n;
        bucket_of = rem[15:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hash_mode_q    = HASH_MODE_RST;
            bucket_count_q = BUCKET_COUNT_RST;
            key_hash       = '0;
            key_open       = 1'b0;
            expected_index.delete();
        end else begin
            // check results first so a result never matches an item of the same cycle
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_index.size() == 0) begin
                    $error("bucket_index: unexpected result, expected none, actual %0d",
                           m_axis_tdata);
                    fail_count++;
                end else begin
                    oldest_index = expected_index.pop_front();
                    if (m_axis_tdata !== oldest_index) begin
                        $error("bucket_index mismatch: expected %0d, actual %0d",
                               oldest_index, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HASH_MODE:    hash_mode_q    = i_cfg_data[1:0];
                    REG_BUCKET_COUNT: bucket_count_q = i_cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    // empty key drops any open key and reports the bare seed
                    key_open = 1'b0;
                    expected_index.push_back(bucket_of(hash_mode_q, key_seed(hash_mode_q)));
                end else begin
                    if (!key_open) begin
                        key_hash = key_seed(hash_mode_q);
                        key_open = 1'b1;
                    end
                    key_hash = fold_char(hash_mode_q, key_hash, s_axis_tdata);
                    if (s_axis_tlast) begin
                        key_open = 1'b0;
                        expected_index.push_back(bucket_of(hash_mode_q, key_hash));
                    end
                end
            end
        end
        o_pending    <= expected_index.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: dv/string_bucket_hash_core_tb.sv
`timescale 1ns / 100ps
// string_bucket_hash_core_tb: drives keys and register writes into the core under random
// flow control and reports the verdict. Depends on sbh_pkg, the core and string_bucket_hash_checker.

module string_bucket_hash_core_tb;
    import sbh_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 95;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = REG_HASH_MODE;
    logic [16:0] i_cfg_data    = '0;

    int pending;
    int fail_count;
    int src_idle_pct     = 8;
    int dst_idle_pct     = 47;
    int hold_off_reqs    = 0;
    int hold_offs_served = 0;
    int quiet_cycles     = 0;
    int phase_items      = 0;

    logic [1:0] mode_cycle[4] = '{MODE_SHIFT, MODE_PROD, MODE_POLY, MODE_SUM};

    string_bucket_hash_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    string_bucket_hash_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result sink: random backpressure, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_reqs != hold_offs_served) begin
                hold_offs_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        logic [7:0] corner[5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 99) < 15)
            pick_byte = corner[$urandom_range(0, 4)];
        else
            pick_byte = 8'($urandom_range(0, 255));
    endfunction

    // leaves tvalid high after the transaction; the next call or settle() takes it over
    task automatic offer_item(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        phase_items++;
    endtask

    // stop offering, wait out every outstanding result, then let any open fold finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_key(input int len);
        for (int i = 0; i < len; i++)
            offer_item(pick_byte(), i == len - 1, 1'b0);
    endtask

    task automatic run_keys(input int count);
        int pick;
        int len;
        phase_items = 0;
        while (phase_items < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                offer_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (pick < 12) begin
                // partial key cut short by an empty key
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    offer_item(pick_byte(), 1'b0, 1'b0);
                offer_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                  : $urandom_range(1, 6);
                send_key(len);
            end
        end
    endtask

    function automatic logic [16:0] count_for_phase(input int p);
        case (p)
            0:       count_for_phase = 17'd1024;
            1:       count_for_phase = 17'd65536;
            2:       count_for_phase = 17'd1;
            3:       count_for_phase = 17'd0;
            4:       count_for_phase = 17'd65535;
            5:       count_for_phase = 17'd2;
            6:       count_for_phase = 17'd131071;
            7:       count_for_phase = 17'd65537;
            9:       count_for_phase = 17'd7;
            10:      count_for_phase = 17'd100000;
            11:      count_for_phase = 17'($urandom_range(1, 131071));
            default: count_for_phase = 17'($urandom_range(3, 65534));
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // polynomial with reset registers: byte extremes, empty key, abandoned key
        offer_item(8'h00, 1'b1, 1'b0);
        offer_item(8'hFF, 1'b0, 1'b0);
        offer_item(8'h80, 1'b0, 1'b0);
        offer_item(8'h7F, 1'b0, 1'b0);
        offer_item(8'h01, 1'b1, 1'b0);
        offer_item(8'hAA, 1'b1, 1'b1);
        offer_item(8'h55, 1'b0, 1'b0);
        offer_item(8'h33, 1'b0, 1'b1);
        // switch to byte sum in the middle of an open key
        offer_item(8'h12, 1'b0, 1'b0);
        offer_item(8'hF0, 1'b0, 1'b0);
        settle();
        write_reg(REG_HASH_MODE, {15'd0, MODE_SUM});
        offer_item(8'h80, 1'b1, 1'b0);
        settle();
        write_reg(REG_HASH_MODE, {15'd0, MODE_SHIFT});
        write_reg(REG_BUCKET_COUNT, 17'd65536);
        offer_item(8'h3F, 1'b0, 1'b0);
        offer_item(8'hC0, 1'b0, 1'b0);
        offer_item(8'hFF, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b1);
        // product reaching -2^31: (-128)^4 * -8
        settle();
        write_reg(REG_HASH_MODE, {15'd0, MODE_PROD});
        write_reg(REG_BUCKET_COUNT, 17'd1000);
        offer_item(8'h80, 1'b0, 1'b0);
        offer_item(8'h80, 1'b0, 1'b0);
        offer_item(8'h80, 1'b0, 1'b0);
        offer_item(8'h80, 1'b0, 1'b0);
        offer_item(8'hF8, 1'b1, 1'b0);
        offer_item(8'h00, 1'b1, 1'b1);
        // zero and oversized bucket counts
        settle();
        write_reg(REG_BUCKET_COUNT, 17'd0);
        offer_item(8'h7E, 1'b1, 1'b0);
        settle();
        write_reg(REG_BUCKET_COUNT, 17'd100000);
        offer_item(8'hFF, 1'b0, 1'b0);
        offer_item(8'h81, 1'b1, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p < 4) begin
                src_idle_pct = 8;
                dst_idle_pct = 47;
            end else if (p < 8) begin
                src_idle_pct = 47;
                dst_idle_pct = 8;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            write_reg(REG_HASH_MODE, {15'd0, mode_cycle[p % 4]});
            write_reg(REG_BUCKET_COUNT, count_for_phase(p));
            if (p == 1)
                hold_off_reqs++;
            if (p == 5) begin
                run_keys(PHASE_ITEMS / 2);
                settle();
                run_keys(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_keys(PHASE_ITEMS);
            end
        end

        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sbh_pkg.sv
rtl/sbh_front.sv
rtl/sbh_queue.sv
rtl/sbh_back.sv
rtl/string_bucket_hash_core.sv
rtl/sbh_checker.sv
dv/string_bucket_hash_checker.sv
dv/string_bucket_hash_core_tb.sv
